>>> src/qsd_pkg.sv
// Shared types, constants and tables for the QOA slice decoder.
// No dependencies; imported by every module of the block.
package qsd_pkg;

  // Block sizing
  localparam int CHANNELS          = 2;
  localparam int SAMPLES_PER_SLICE = 20;
  localparam int LMS_TAPS          = 4;
  localparam int PRED_SHIFT        = 13;
  localparam int Q_DEPTH           = 2;

  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_W     = $clog2(SAMPLES_PER_SLICE);
  localparam int CODE_BITS  = 3 * SAMPLES_PER_SLICE;
  localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // Request kinds
  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_DECODE = 1'b1
  } req_t;

  // One queued request word
  typedef struct packed {
    req_t        kind;
    logic        ch;
    logic [63:0] slice_word;
    logic [63:0] history_word;
    logic [63:0] weights_word;
  } qsd_entry_t;

  // Dequantization scale, round((s+1)^2.75)
  function automatic logic [11:0] scale_of(input logic [3:0] idx);
    logic [11:0] v;
    case (idx)
      4'd0:    v = 12'd1;
      4'd1:    v = 12'd7;
      4'd2:    v = 12'd21;
      4'd3:    v = 12'd45;
      4'd4:    v = 12'd84;
      4'd5:    v = 12'd138;
      4'd6:    v = 12'd211;
      4'd7:    v = 12'd304;
      4'd8:    v = 12'd421;
      4'd9:    v = 12'd562;
      4'd10:   v = 12'd731;
      4'd11:   v = 12'd928;
      4'd12:   v = 12'd1157;
      4'd13:   v = 12'd1419;
      4'd14:   v = 12'd1715;
      default: v = 12'd2048;
    endcase
    return v;
  endfunction

  // Residual multiplier in quarter units: 0.75, 2.5, 4.5, 7
  function automatic logic [4:0] quarter_of(input logic [1:0] sel);
    logic [4:0] v;
    case (sel)
      2'd0:    v = 5'd3;
      2'd1:    v = 5'd10;
      2'd2:    v = 5'd18;
      default: v = 5'd28;
    endcase
    return v;
  endfunction

endpackage

>>> src/qsd_front.sv
// Front end of the QOA slice decoder: input handshake, channel range check
// and a short request queue toward the back end. Depends on qsd_pkg.
module qsd_front
  import qsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        channel,
  input  logic [63:0] slice_word,
  input  logic [63:0] history_word,
  input  logic [63:0] weights_word,
  output logic        q_valid,
  input  logic        q_pop,
  output qsd_entry_t  q_head
);

  qsd_entry_t         entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  logic ch_ok;
  logic push;
  logic pop;

  // Words for a channel outside the configured set are taken and dropped
  assign ch_ok    = (32'(channel) < CHANNELS);
  assign in_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && in_ready && ch_ok;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_head   = entries[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{kind: req_t'(req_type), ch: channel, slice_word: slice_word,
                           history_word: history_word, weights_word: weights_word};
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/qsd_back.sv
// Back end of the QOA slice decoder: per-channel LMS state, the sample
// loop (dequantize, predict, saturate, adapt) and the output register.
// Depends on qsd_pkg.
module qsd_back
  import qsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  qsd_entry_t         q_head,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               sample_channel,
  output logic               last
);

  // LMS state per channel
  logic signed [15:0] hist [CHANNELS][LMS_TAPS];
  logic signed [15:0] wts  [CHANNELS][LMS_TAPS];

  // Slice in progress
  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [CODE_BITS-1:0] codes;
  logic [3:0]           scale_idx;
  logic [CH_IDX_W-1:0]  cur_ch;
  logic                 cur_ch_bit;

  logic                 adv;
  logic                 last_step;
  logic                 take;
  logic                 take_load;
  logic                 take_dec;
  logic [CH_IDX_W-1:0]  head_ch;

  logic [2:0]           code;
  logic [16:0]          prod;
  logic [14:0]          mag;
  logic signed [15:0]   resid;
  logic signed [15:0]   delta;
  logic signed [31:0]   tap_prod [LMS_TAPS];
  logic signed [33:0]   acc;
  logic signed [20:0]   pred;
  logic signed [21:0]   s_full;
  logic signed [15:0]   s_sat;
  logic signed [15:0]   h_cur [LMS_TAPS];
  logic signed [15:0]   w_cur [LMS_TAPS];
  logic signed [15:0]   h_next [LMS_TAPS];
  logic signed [15:0]   w_next [LMS_TAPS];

  // Sequencing: a step runs whenever the output register can take it
  assign adv       = busy && (!out_valid || out_ready);
  assign last_step = (step == STEP_W'(SAMPLES_PER_SLICE - 1));
  assign take      = q_valid && (!busy || (adv && last_step));
  assign q_pop     = take;
  assign take_load = take && (q_head.kind == REQ_LOAD);
  assign take_dec  = take && (q_head.kind == REQ_DECODE);
  assign head_ch   = CH_IDX_W'(q_head.ch);

  // Dequantized residual, exact in quarter units with half-away rounding
  always_comb begin
    code  = codes[CODE_BITS-1 -: 3];
    prod  = 17'(scale_of(scale_idx)) * 17'(quarter_of(code[2:1]));
    mag   = 15'((prod + 17'd2) >> 2);
    resid = code[0] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    delta = resid >>> 4;
  end

  // Prediction, sample, and the adapted state for the next step
  always_comb begin
    for (int n = 0; n < LMS_TAPS; n++) begin
      h_cur[n]    = hist[cur_ch][n];
      w_cur[n]    = wts[cur_ch][n];
      tap_prod[n] = h_cur[n] * w_cur[n];
    end
    acc = '0;
    for (int n = 0; n < LMS_TAPS; n++) begin
      acc = acc + 34'(tap_prod[n]);
    end
    pred   = 21'(acc >>> PRED_SHIFT);
    s_full = 22'(pred) + 22'(resid);
    if (s_full > 22'sd32767) begin
      s_sat = 16'sh7fff;
    end else if (s_full < -22'sd32768) begin
      s_sat = 16'sh8000;
    end else begin
      s_sat = s_full[15:0];
    end
    for (int n = 0; n < LMS_TAPS; n++) begin
      w_next[n] = h_cur[n][15] ? (w_cur[n] - delta) : (w_cur[n] + delta);
    end
    for (int n = 0; n < LMS_TAPS - 1; n++) begin
      h_next[n] = h_cur[n + 1];
    end
    h_next[LMS_TAPS-1] = s_sat;
  end

  // LMS state: a load word overrides the final update of the slice before it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int n = 0; n < LMS_TAPS; n++) begin
          hist[c][n] <= '0;
          wts[c][n]  <= '0;
        end
      end
    end else begin
      if (adv) begin
        for (int n = 0; n < LMS_TAPS; n++) begin
          hist[cur_ch][n] <= h_next[n];
          wts[cur_ch][n]  <= w_next[n];
        end
      end
      if (take_load) begin
        for (int n = 0; n < LMS_TAPS; n++) begin
          hist[head_ch][n] <= q_head.history_word[63 - 16*n -: 16];
          wts[head_ch][n]  <= q_head.weights_word[63 - 16*n -: 16];
        end
      end
    end
  end

  // Slice sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else begin
      if (adv) begin
        step <= step + 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
      if (take_dec) begin
        busy <= 1'b1;
        step <= '0;
      end
    end
  end

  // Slice payload: codes shift up one step per sample
  always_ff @(posedge clk) begin
    if (take_dec) begin
      codes      <= q_head.slice_word[CODE_BITS-1:0];
      scale_idx  <= q_head.slice_word[63:60];
      cur_ch     <= head_ch;
      cur_ch_bit <= q_head.ch;
    end else if (adv) begin
      codes <= {codes[CODE_BITS-4:0], 3'b000};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample         <= s_sat;
      sample_channel <= cur_ch_bit;
      last           <= last_step;
    end
  end

  // Checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step <= STEP_W'(SAMPLES_PER_SLICE - 1)))
    else $error("step counter past end of slice");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (adv && last_step) |=> (out_valid && last))
    else $error("final sample of slice not flagged last");

  a_mid_flag: assert property (@(posedge clk) disable iff (rst)
    (adv && !last_step) |=> (out_valid && !last))
    else $error("last flagged before end of slice");

  a_no_take_mid: assert property (@(posedge clk) disable iff (rst)
    (take && busy) |-> (adv && last_step))
    else $error("queue popped in the middle of a slice");

endmodule

>>> src/qoa_slice_decoder.sv
// QOA slice decoder, top level: request queue front end plus LMS sample
// back end. Depends on qsd_pkg, qsd_front and qsd_back.
//
// Each decode word yields twenty samples, one sample per clock while the output
// is not stalled; the rate is set by the LMS feedback loop (four-tap
// multiply-accumulate, residual add, saturate and weight update), since
// each sample enters the history used by the next one. A new slice starts
// in the cycle after the last sample of the previous one, with no gap. A
// load word does not start the sample loop but writes the LMS state of its
// channel as it is taken. A two-word queue between input and back end keeps
// the input open while a slice runs, and the output register lets the back
// end keep stepping as long as words are taken. Words naming a channel
// outside the configured set are accepted and dropped.
module qoa_slice_decoder
  import qsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic               channel,
  input  logic [63:0]        slice_word,
  input  logic [63:0]        history_word,
  input  logic [63:0]        weights_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample,
  output logic               sample_channel,
  output logic               last
);

  logic       q_valid;
  logic       q_pop;
  qsd_entry_t q_head;

  qsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .channel      (channel),
    .slice_word   (slice_word),
    .history_word (history_word),
    .weights_word (weights_word),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_head       (q_head)
  );

  qsd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_head         (q_head),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample),
    .sample_channel (sample_channel),
    .last           (last)
  );

endmodule

>>> tb/sv/qoa_slice_decoder_tb.sv
// Self-checking testbench for qoa_slice_decoder: queued driver, randomly stalling sink,
// and a built-in LMS predictor that checks every decoded sample field by field.
// Depends on qsd_pkg and the qoa_slice_decoder RTL.
module qoa_slice_decoder_tb;
  import qsd_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_WORDS  = 480;

  typedef struct {
    logic signed [15:0] pcm;
    logic               ch;
    logic               last_flag;
  } pcm_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic               req_type     = 1'b0;
  logic               channel      = 1'b0;
  logic [63:0]        slice_word   = '0;
  logic [63:0]        history_word = '0;
  logic [63:0]        weights_word = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [15:0] sample;
  logic               sample_channel;
  logic               last;

  // Words waiting to be offered, and samples waiting to come out
  qsd_entry_t pending[$];
  qsd_entry_t cur;
  pcm_t       pcm_expected[$];

  // Predictor state: per-channel LMS history and weights
  logic signed [15:0] hist_st [CHANNELS][LMS_TAPS];
  logic signed [15:0] wgt_st  [CHANNELS][LMS_TAPS];

  int unsigned scale_lut [16] = '{1, 7, 21, 45, 84, 138, 211, 304,
                                  421, 562, 731, 928, 1157, 1419, 1715, 2048};
  int unsigned quarter_lut [4] = '{3, 10, 18, 28};

  int cycles       = 0;
  int mismatches   = 0;
  int samples_seen = 0;
  int loads_in     = 0;
  int slices_in    = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int hold_left    = 0;

  qoa_slice_decoder dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Slice with scale index sc; code k is (first + step*k) mod 8
  function automatic logic [63:0] make_slice(input logic [3:0] sc, input int first,
                                             input int step);
    logic [63:0] v;
    int k;
    v = '0;
    v[63:60] = sc;
    for (k = 0; k < SAMPLES_PER_SLICE; k++) v[59-3*k -: 3] = 3'(first + step * k);
    return v;
  endfunction

  // Four signed taps, each in [-span, span]
  function automatic logic [63:0] rand_taps(input int span);
    logic [63:0] v;
    int n;
    for (n = 0; n < LMS_TAPS; n++) v[63-16*n -: 16] = 16'($urandom_range(0, 2 * span) - span);
    return v;
  endfunction

  task automatic queue_word(input req_t kind, input logic ch, input logic [63:0] sl,
                            input logic [63:0] hi, input logic [63:0] wt);
    qsd_entry_t w;
    w.kind         = kind;
    w.ch           = ch;
    w.slice_word   = sl;
    w.history_word = hi;
    w.weights_word = wt;
    pending = {pending, w};
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch after %0d samples: %s expected %0d got %0d",
               samples_seen, what, want, got);
  endtask

  // Apply one accepted word to the predictor; a slice queues its twenty samples
  task automatic predict_pcm(input qsd_entry_t w);
    int          k, n, mag, resid, delta, s;
    longint      acc;
    logic [2:0]  code;
    int unsigned scale;
    pcm_t        exp_pcm;
    if (int'(w.ch) >= CHANNELS) return;
    if (w.kind == REQ_LOAD) begin
      for (n = 0; n < LMS_TAPS; n++) begin
        hist_st[w.ch][n] = w.history_word[63-16*n -: 16];
        wgt_st[w.ch][n]  = w.weights_word[63-16*n -: 16];
      end
      return;
    end
    scale = scale_lut[w.slice_word[63:60]];
    for (k = 0; k < SAMPLES_PER_SLICE; k++) begin
      code  = w.slice_word[59-3*k -: 3];
      mag   = int'((scale * quarter_lut[code[2:1]] + 2) >> 2);
      resid = code[0] ? -mag : mag;
      acc   = 0;
      for (n = 0; n < LMS_TAPS; n++)
        acc += longint'(hist_st[w.ch][n]) * longint'(wgt_st[w.ch][n]);
      // arithmetic shift floors the prediction
      s = int'(acc >>> PRED_SHIFT) + resid;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      delta = resid >>> 4;
      // weights follow the sign of their history tap, wrapping at 16 bits
      for (n = 0; n < LMS_TAPS; n++) begin
        if (hist_st[w.ch][n] < 0) wgt_st[w.ch][n] = wgt_st[w.ch][n] - 16'(delta);
        else wgt_st[w.ch][n] = wgt_st[w.ch][n] + 16'(delta);
      end
      for (n = 0; n < LMS_TAPS - 1; n++) hist_st[w.ch][n] = hist_st[w.ch][n+1];
      hist_st[w.ch][LMS_TAPS-1] = 16'(s);
      exp_pcm = '{16'(s), w.ch, k == SAMPLES_PER_SLICE - 1};
      pcm_expected = {pcm_expected, exp_pcm};
    end
  endtask

  // Driver: offer queued words, predict on acceptance
  always @(posedge clk) begin
    int c, n;
    if (rst) begin
      in_valid <= 1'b0;
      for (c = 0; c < CHANNELS; c++)
        for (n = 0; n < LMS_TAPS; n++) begin
          hist_st[c][n] = '0;
          wgt_st[c][n]  = '0;
        end
    end else begin
      if (in_valid && in_ready) begin
        predict_pcm(cur);
        if (cur.kind == REQ_LOAD) loads_in++;
        else slices_in++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          cur = pending.pop_front();
          in_valid     <= 1'b1;
          req_type     <= cur.kind;
          channel      <= cur.ch;
          slice_word   <= cur.slice_word;
          history_word <= cur.history_word;
          weights_word <= cur.weights_word;
          send_gap = pick_gap((cycles / 1500) % 4 == 1);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Sink: random stalls, plus two long hold-offs that back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (cycles == 2000 || cycles == 7000) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap((cycles / 1100) % 4 == 2);
      end
    end
  end

  // Monitor: compare each taken sample word against the oldest prediction
  always @(posedge clk) begin
    pcm_t want;
    if (!rst && out_valid && out_ready) begin
      samples_seen++;
      if (pcm_expected.size() == 0) begin
        flag_mismatch("sample with none pending", 0, int'(sample));
      end else begin
        want = pcm_expected.pop_front();
        if (sample !== want.pcm) flag_mismatch("sample", int'(want.pcm), int'(sample));
        if (sample_channel !== want.ch)
          flag_mismatch("sample_channel", int'(want.ch), int'(sample_channel));
        if (last !== want.last_flag) flag_mismatch("last", int'(want.last_flag), int'(last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("qoa_slice_decoder_tb: errors");
      $finish;
    end
  end

  initial begin
    int i, r;
    logic ch;

    // Directed: saturation both ways, every code at scale 0 and scale 8
    queue_word(REQ_LOAD, 1'b0, {$urandom, $urandom}, {4{16'h7FFF}}, {4{16'h7FFF}});
    queue_word(REQ_DECODE, 1'b0, make_slice(4'd15, 0, 0), '0, '0);
    queue_word(REQ_DECODE, 1'b0, make_slice(4'd15, 7, 0), '0, '0);
    queue_word(REQ_LOAD, 1'b1, '0, {4{16'h8000}}, {4{16'h7FFF}});
    queue_word(REQ_DECODE, 1'b1, make_slice(4'd15, 7, 0), '0, '0);
    queue_word(REQ_LOAD, 1'b0, '0, '0, '0);
    queue_word(REQ_DECODE, 1'b0, make_slice(4'd0, 0, 1), '0, '0);
    queue_word(REQ_DECODE, 1'b0, make_slice(4'd8, 0, 1), '0, '0);
    // weights near the top wrap on the first large positive residual
    queue_word(REQ_LOAD, 1'b1, '0, {4{16'h0001}}, {4{16'h7FF0}});
    queue_word(REQ_DECODE, 1'b1, make_slice(4'd15, 6, 0), '0, '0);
    queue_word(REQ_DECODE, 1'b1, make_slice(4'd15, 6, 0), '0, '0);
    // mixed-sign history so weights move both ways
    queue_word(REQ_LOAD, 1'b0, '0, {16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF},
               {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
    queue_word(REQ_DECODE, 1'b0, {64{1'b1}}, '0, '0);
    queue_word(REQ_DECODE, 1'b0, '0, '0, '0);
    // ignored fields at their extremes
    queue_word(REQ_LOAD, 1'b1, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    queue_word(REQ_DECODE, 1'b1, make_slice(4'd1, 2, 3), {64{1'b1}}, {64{1'b1}});
    // back-to-back loads, then slices on alternating channels
    queue_word(REQ_LOAD, 1'b0, '0, rand_taps(3000), rand_taps(16000));
    queue_word(REQ_LOAD, 1'b1, '0, rand_taps(3000), rand_taps(16000));
    queue_word(REQ_DECODE, 1'b0, make_slice(4'd4, 5, 1), '0, '0);
    queue_word(REQ_DECODE, 1'b1, make_slice(4'd12, 3, 5), '0, '0);
    queue_word(REQ_DECODE, 1'b0, make_slice(4'd7, 1, 2), '0, '0);

    // Random: mostly slices on a loaded predictor, some loads, a few raw states
    for (i = 0; i < RAND_WORDS; i++) begin
      r  = $urandom_range(0, 99);
      ch = 1'($urandom);
      if (r < 10)
        queue_word(REQ_LOAD, ch, {$urandom, $urandom}, rand_taps(4000), rand_taps(20000));
      else if (r < 14)
        queue_word(REQ_LOAD, ch, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
      else
        queue_word(REQ_DECODE, ch, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (pcm_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pcm_expected.size() != 0)
      flag_mismatch("samples never produced", pcm_expected.size(), 0);

    $display("run covered %0d load words and %0d slice words, %0d samples checked",
             loads_in, slices_in, samples_seen);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("qoa_slice_decoder_tb: clean");
    end else begin
      $display("qoa_slice_decoder_tb: errors");
    end
    $finish;
  end

endmodule
